FILE: design/klvd_pkg.sv
// Package for the KLV telemetry deframer: constants, byte kinds, error codes,
// the parse phase type and the result record used by klvd_core, klvd_out_stage
// and the top level. No dependencies.
`default_nettype none

package klvd_pkg;

  localparam int LEVELS    = 3;
  localparam int LVL_IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int REM_W     = 24;
  localparam int HDR_BYTES = 8;

  localparam logic [31:0] TOP_KEY_RESET = 32'h44455643;

  // Format byte that marks a token whose payload holds child tokens.
  localparam logic [7:0] FMT_CONTAINER = 8'h00;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_DATA    = 2'd1;
  localparam logic [1:0] KIND_PAD     = 2'd2;
  localparam logic [1:0] KIND_DISCARD = 2'd3;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TOP_KEY = 2'd1;
  localparam logic [1:0] ERR_OVERRUN = 2'd2;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_DATA   = 4'b0010,
    PH_PAD    = 4'b0100,
    PH_ERROR  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]  byte_kind;
    logic [2:0]  level;
    logic        header_done;
    logic [31:0] token_key;
    logic [7:0]  format_code;
    logic [7:0]  element_size;
    logic [15:0] repeat_count;
    logic        is_container;
    logic        element_last;
    logic        token_last;
    logic [1:0]  error_code;
  } result_t;

endpackage

`default_nettype wire

FILE: design/klvd_in_stage.sv
// Input register of the deframer: holds one stream byte in front of the parser.
// Depends on nothing but the clock and reset.
`default_nettype none

module klvd_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            s1_valid,
  output logic [7:0]      s1_byte,
  input  wire logic       s1_taken
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // The held byte blocks the input only while the parser cannot take it.
  assign in_stall  = valid_r && !s1_taken;
  assign valid_nxt = in_stall ? 1'b1 : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

`default_nettype wire

FILE: design/klvd_core.sv
// Parser state of the deframer: header assembly, size check against the open
// containers, data and padding counters, and the labelling of each byte.
// Depends on klvd_pkg.
`default_nettype none

module klvd_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire logic [7:0]       cur_byte,
  input  wire logic [31:0]      top_key,
  output klvd_pkg::result_t     res
);

  logic [55:0]                      header_shift_r, header_shift_nxt;
  logic [2:0]                       header_count_r, header_count_nxt;
  logic [klvd_pkg::LVL_IDX_W-1:0]   cur_level_r, cur_level_nxt;
  logic [klvd_pkg::REM_W-1:0]       stack_r [klvd_pkg::LEVELS];
  logic [klvd_pkg::REM_W-1:0]       stack_nxt [klvd_pkg::LEVELS];
  logic [1:0]                       pad_left_r, pad_left_nxt;
  logic [7:0]                       element_count_r, element_count_nxt;
  klvd_pkg::phase_t                 phase_r, phase_nxt;
  logic [1:0]                       err_r, err_nxt;
  logic [klvd_pkg::REM_W-1:0]       data_left_r, data_left_nxt;
  logic [31:0]                      t_key_r, t_key_nxt;
  logic [7:0]                       t_fmt_r, t_fmt_nxt;
  logic [7:0]                       t_size_r, t_size_nxt;
  logic [15:0]                      t_rep_r, t_rep_nxt;

  logic [31:0]                      h_key;
  logic [7:0]                       h_fmt;
  logic [7:0]                       h_size;
  logic [15:0]                      h_rep;
  logic [klvd_pkg::REM_W-1:0]       payload;
  logic [1:0]                       pad;
  logic [klvd_pkg::REM_W:0]         total;
  logic [klvd_pkg::LVL_IDX_W-1:0]   parent_idx;
  logic [klvd_pkg::REM_W-1:0]       parent_rem;
  logic                             can_open;
  logic                             data_done;
  logic [klvd_pkg::REM_W-1:0]       data_dec;
  logic                             do_close;
  logic [klvd_pkg::LVL_IDX_W-1:0]   close_lvl;

  // Header fields as they stand once the eighth byte arrives.
  assign h_key      = header_shift_r[55:24];
  assign h_fmt      = header_shift_r[23:16];
  assign h_size     = header_shift_r[15:8];
  assign h_rep      = {header_shift_r[7:0], cur_byte};
  assign payload    = h_size * h_rep;
  assign pad        = 2'd0 - payload[1:0];
  assign total      = (klvd_pkg::REM_W+1)'(klvd_pkg::HDR_BYTES) + {1'b0, payload}
                      + (klvd_pkg::REM_W+1)'(pad);
  assign parent_idx = cur_level_r - 1'b1;
  assign parent_rem = stack_r[parent_idx];
  assign can_open   = (h_fmt == klvd_pkg::FMT_CONTAINER)
                      && (int'(cur_level_r) + 1 < klvd_pkg::LEVELS);
  assign data_dec   = (data_left_r != '0) ? data_left_r - 1'b1 : data_left_r;
  assign data_done  = (data_dec == '0);

  always_comb begin
    header_shift_nxt  = header_shift_r;
    header_count_nxt  = header_count_r;
    cur_level_nxt     = cur_level_r;
    stack_nxt         = stack_r;
    pad_left_nxt      = pad_left_r;
    element_count_nxt = element_count_r;
    phase_nxt         = phase_r;
    err_nxt           = err_r;
    data_left_nxt     = data_left_r;
    t_key_nxt         = t_key_r;
    t_fmt_nxt         = t_fmt_r;
    t_size_nxt        = t_size_r;
    t_rep_nxt         = t_rep_r;
    do_close          = 1'b0;
    res               = '0;

    case (phase_r)
      klvd_pkg::PH_HEADER: begin
        res.byte_kind = klvd_pkg::KIND_HEADER;
        res.level     = 3'(cur_level_r);
        if (header_count_r != 3'(klvd_pkg::HDR_BYTES - 1)) begin
          header_shift_nxt = {header_shift_r[47:0], cur_byte};
          header_count_nxt = header_count_r + 3'd1;
        end else begin
          header_count_nxt = 3'd0;
          t_key_nxt        = h_key;
          t_fmt_nxt        = h_fmt;
          t_size_nxt       = h_size;
          t_rep_nxt        = h_rep;
          res.header_done  = 1'b1;
          res.token_key    = h_key;
          res.format_code  = h_fmt;
          res.element_size = h_size;
          res.repeat_count = h_rep;
          if ((cur_level_r == '0) && (h_key != top_key)) begin
            err_nxt   = klvd_pkg::ERR_TOP_KEY;
            phase_nxt = klvd_pkg::PH_ERROR;
          end else if ((cur_level_r != '0) && (total > {1'b0, parent_rem})) begin
            err_nxt   = klvd_pkg::ERR_OVERRUN;
            phase_nxt = klvd_pkg::PH_ERROR;
          end else begin
            if (cur_level_r != '0) begin
              stack_nxt[parent_idx] = parent_rem - total[klvd_pkg::REM_W-1:0];
            end
            if (can_open) begin
              res.is_container = 1'b1;
              if (pad != 2'd0) begin
                // A container whose size is not a multiple of four can never
                // be filled exactly by child tokens.
                err_nxt   = klvd_pkg::ERR_OVERRUN;
                phase_nxt = klvd_pkg::PH_ERROR;
              end else begin
                stack_nxt[cur_level_r] = payload;
                if (payload == '0) begin
                  res.token_last = 1'b1;
                  do_close       = 1'b1;
                end else begin
                  cur_level_nxt = cur_level_r + 1'b1;
                end
              end
            end else begin
              data_left_nxt     = payload;
              pad_left_nxt      = pad;
              element_count_nxt = 8'd0;
              if (payload == '0) begin
                res.token_last = 1'b1;
                do_close       = 1'b1;
              end else begin
                phase_nxt = klvd_pkg::PH_DATA;
              end
            end
          end
        end
      end
      klvd_pkg::PH_DATA: begin
        res.byte_kind    = klvd_pkg::KIND_DATA;
        res.level        = 3'(cur_level_r);
        res.token_key    = t_key_r;
        res.format_code  = t_fmt_r;
        res.element_size = t_size_r;
        res.repeat_count = t_rep_r;
        if ({1'b0, element_count_r} + 9'd1 >= {1'b0, t_size_r}) begin
          res.element_last  = 1'b1;
          element_count_nxt = 8'd0;
        end else begin
          element_count_nxt = element_count_r + 8'd1;
        end
        data_left_nxt = data_dec;
        if (data_done) begin
          if (pad_left_r == 2'd0) begin
            res.token_last = 1'b1;
            do_close       = 1'b1;
          end else begin
            phase_nxt = klvd_pkg::PH_PAD;
          end
        end
      end
      klvd_pkg::PH_PAD: begin
        res.byte_kind    = klvd_pkg::KIND_PAD;
        res.level        = 3'(cur_level_r);
        res.token_key    = t_key_r;
        res.format_code  = t_fmt_r;
        res.element_size = t_size_r;
        res.repeat_count = t_rep_r;
        if (pad_left_r != 2'd0) begin
          pad_left_nxt = pad_left_r - 2'd1;
        end
        if (pad_left_r <= 2'd1) begin
          res.token_last = 1'b1;
          do_close       = 1'b1;
        end
      end
      default: begin
        res.byte_kind = klvd_pkg::KIND_DISCARD;
      end
    endcase

    // A finished token also closes every parent that has nothing unclaimed:
    // the next header goes to the deepest level whose parent still has room.
    close_lvl = '0;
    for (int j = 1; j < klvd_pkg::LEVELS; j++) begin
      if ((j <= int'(cur_level_r)) && (stack_nxt[j-1] != '0)) begin
        close_lvl = klvd_pkg::LVL_IDX_W'(j);
      end
    end
    if (do_close) begin
      cur_level_nxt    = close_lvl;
      phase_nxt        = klvd_pkg::PH_HEADER;
      header_count_nxt = 3'd0;
    end

    res.error_code = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r  <= 3'd0;
      cur_level_r     <= '0;
      stack_r         <= '{default: '0};
      pad_left_r      <= 2'd0;
      element_count_r <= 8'd0;
      phase_r         <= klvd_pkg::PH_HEADER;
      err_r           <= klvd_pkg::ERR_NONE;
      data_left_r     <= '0;
    end else if (fire) begin
      header_count_r  <= header_count_nxt;
      cur_level_r     <= cur_level_nxt;
      stack_r         <= stack_nxt;
      pad_left_r      <= pad_left_nxt;
      element_count_r <= element_count_nxt;
      phase_r         <= phase_nxt;
      err_r           <= err_nxt;
      data_left_r     <= data_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      header_shift_r <= header_shift_nxt;
      t_key_r        <= t_key_nxt;
      t_fmt_r        <= t_fmt_nxt;
      t_size_r       <= t_size_nxt;
      t_rep_r        <= t_rep_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/klvd_out_stage.sv
// Result register of the deframer: holds one labelled byte until the
// consumer takes it. Depends on klvd_pkg.
`default_nettype none

module klvd_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               res_valid,
  input  wire klvd_pkg::result_t  res,
  output logic                    res_taken,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output klvd_pkg::result_t       out_res
);

  logic              valid_r;
  logic              valid_nxt;
  logic              hold;
  klvd_pkg::result_t res_r;

  assign hold      = valid_r && out_stall;
  assign res_taken = res_valid && !hold;
  assign valid_nxt = hold ? 1'b1 : res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

FILE: design/klv_telemetry_deframer_unit.sv
// Top level of the KLV telemetry deframer: input register, parser, result
// register and the top key register. Depends on klvd_pkg and the klvd modules.
`default_nettype none

// The deframer takes one stream byte per clock while no result is held, and
// returns one labelled result per byte, in order. A byte is registered in the
// input register and its result in the result register, from which the
// consumer takes it. Header assembly, the size-times-repeat product, the
// check against the parent container and the counter updates all sit in the
// single stage between those registers, so a byte can follow every cycle
// while no result is held. A held result stalls the input only when the input
// register is also full. After a top key mismatch or an overrun every byte is
// labelled as discarded until reset. Write top_key only while idle.
module klv_telemetry_deframer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_byte_kind,
  output logic [2:0]       out_level,
  output logic             out_header_done,
  output logic [31:0]      out_token_key,
  output logic [7:0]       out_format_code,
  output logic [7:0]       out_element_size,
  output logic [15:0]      out_repeat_count,
  output logic             out_is_container,
  output logic             out_element_last,
  output logic             out_token_last,
  output logic [1:0]       out_error_code
);

  logic [31:0]       top_key_r;
  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_taken;
  klvd_pkg::result_t core_res;
  klvd_pkg::result_t out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_key_r <= klvd_pkg::TOP_KEY_RESET;
    end else if (cfg_wr_en) begin
      top_key_r <= cfg_wr_data;
    end
  end

  klvd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte),
    .s1_taken (s1_taken)
  );

  klvd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_taken),
    .cur_byte (s1_byte),
    .top_key  (top_key_r),
    .res      (core_res)
  );

  klvd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (s1_valid),
    .res       (core_res),
    .res_taken (s1_taken),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte_kind    = out_res.byte_kind;
  assign out_level        = out_res.level;
  assign out_header_done  = out_res.header_done;
  assign out_token_key    = out_res.token_key;
  assign out_format_code  = out_res.format_code;
  assign out_element_size = out_res.element_size;
  assign out_repeat_count = out_res.repeat_count;
  assign out_is_container = out_res.is_container;
  assign out_element_last = out_res.element_last;
  assign out_token_last   = out_res.token_last;
  assign out_error_code   = out_res.error_code;

  // The input is held back only while a finished result is waiting.
  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result register could advance");

  a_discard_has_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_byte_kind == klvd_pkg::KIND_DISCARD))
      |-> (out_error_code != klvd_pkg::ERR_NONE))
    else $error("discarded byte without an error code");

  a_done_is_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_header_done) |-> (out_byte_kind == klvd_pkg::KIND_HEADER))
    else $error("header_done on a byte that is not a header byte");

  a_container_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_container)
      |-> (out_header_done && (out_format_code == klvd_pkg::FMT_CONTAINER)))
    else $error("container flag outside the last header byte of a format-zero token");

endmodule

`default_nettype wire
